### src/firlc_pkg.sv
// Shared constants, codes and types for the FIR linear convolution unit.
// No dependencies; every other source file imports this package.
package firlc_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int TAP_W       = $clog2(MAX_TAPS);
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_BITS = 16;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = 40;
  localparam int TAPCFG_W    = 7;
  localparam int STRIDE_W    = 4;
  localparam int MAX_STRIDE  = 8;
  localparam int FPOS_W      = 3;
  localparam int COEFF_IDX_W = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_STRIDE = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;   // start a new sum of products
    logic valid;   // operands of one tap are present
  } mac_ctrl_t;

endpackage

### src/firlc_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on firlc_pkg for field widths.
interface firlc_in_if import firlc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [COEFF_IDX_W-1:0]        coeff_index;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last_sample;

  modport source (output valid, action, coeff_index, value, last_sample, input ready);
  modport sink   (input valid, action, coeff_index, value, last_sample, output ready);
endinterface

interface firlc_out_if import firlc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;
  logic                    end_of_run;

  modport source (output valid, sum, end_of_run, input ready);
  modport sink   (input valid, sum, end_of_run, output ready);
endinterface

### src/firlc_mac.sv
// Two-stage multiply-accumulate: registered product, then 40-bit accumulator.
// Depends on firlc_pkg.
module firlc_mac import firlc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] coeff_i,
  output logic signed [SUM_W-1:0]       acc_o,
  output logic                          busy_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid_q;
  logic signed [SUM_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coeff_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_valid_q;

endmodule

### src/fir_linear_convolution_unit.sv
// Streaming full linear convolution with a kernel of up to MAX_TAPS taps.
// A filtered sample's sum is formed tap by tap through the memory read stage, the product
// register and the accumulator; each tail sum of a flush starts once the previous one is loaded.
// Throughput is set by the single shared multiplier, one tap per cycle from two memories while
// a sum is formed. Reset (rst_ni, asynchronous, active low) empties
// the delay line, zeroes the frame position and sets tap_count 64 and channel_stride 1.
module fir_linear_convolution_unit import firlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  firlc_in_if.sink              in_i,
  firlc_out_if.source           out_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  // Configuration registers.
  logic [TAPCFG_W-1:0] tap_count_q;
  logic [STRIDE_W-1:0] stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAPCFG_W'(MAX_TAPS);
      stride_q    <= STRIDE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_COUNT:      tap_count_q <= cfg_wdata_i[TAPCFG_W-1:0];
        REG_CHANNEL_STRIDE: stride_q    <= cfg_wdata_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective tap count and stride, with out-of-range values clamped.
  logic [CNT_W-1:0]    taps;
  logic [STRIDE_W-1:0] stride_eff;

  always_comb begin
    if (tap_count_q == '0) begin
      taps = CNT_W'(1);
    end else if (tap_count_q > TAPCFG_W'(MAX_TAPS)) begin
      taps = CNT_W'(MAX_TAPS);
    end else begin
      taps = CNT_W'(tap_count_q);
    end
    if (stride_q == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (stride_q > STRIDE_W'(MAX_STRIDE)) begin
      stride_eff = STRIDE_W'(MAX_STRIDE);
    end else begin
      stride_eff = stride_q;
    end
  end

  // Sequencer state.
  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  k_q, k_d;          // next tap to read
  logic [TAP_W-1:0]  wp_q, wp_d;        // delay line head in the circular buffer
  logic [FPOS_W-1:0] fpos_q, fpos_d;
  logic [CNT_W-1:0]  flush_q, flush_d;  // tail sums still to produce
  logic              last_run_q, last_run_d;
  logic              st1_v_q;           // memory read stage holds a tap

  logic                          in_fire;
  logic                          issue;
  logic                          kwe;
  logic                          dwe;
  logic signed [SAMPLE_BITS-1:0] dwdata;
  logic                          clr_valid;
  logic                          mac_clear;
  logic                          out_load;
  logic                          mac_busy;
  logic [STRIDE_W-1:0]           fpos_p1;
  logic [FPOS_W-1:0]             fpos_next;
  logic [TAP_W-1:0]              waddr;
  logic [TAP_W-1:0]              raddr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Frame position advances on every sample transaction and wraps at the stride; a last sample resets it.
  assign fpos_p1   = STRIDE_W'(fpos_q) + STRIDE_W'(1);
  assign fpos_next = (fpos_p1 >= stride_eff) ? '0 : fpos_p1[FPOS_W-1:0];

  // Shifting into the delay line moves the head back by one entry; tap k of the
  // line sits k entries past the head.
  assign waddr = wp_q - TAP_W'(1);
  assign raddr = wp_q + k_q[TAP_W-1:0];

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    wp_d       = wp_q;
    fpos_d     = fpos_q;
    flush_d    = flush_q;
    last_run_d = last_run_q;
    issue      = 1'b0;
    kwe        = 1'b0;
    dwe        = 1'b0;
    dwdata     = '0;
    clr_valid  = 1'b0;
    mac_clear  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.action == ACT_LOAD) begin
            kwe = 1'b1;
          end else begin
            fpos_d = in_i.last_sample ? '0 : fpos_next;
            if (fpos_q == '0) begin
              // Filtered sample: shift it in and sum over the taps.
              dwe        = 1'b1;
              dwdata     = in_i.value;
              flush_d    = in_i.last_sample ? taps - CNT_W'(1) : '0;
              last_run_d = in_i.last_sample;
              wp_d       = waddr;
              k_d        = '0;
              mac_clear  = 1'b1;
              state_d    = ST_SUM;
            end else if (in_i.last_sample) begin
              // A skipped sample that ends the signal still flushes the tail.
              if (taps > CNT_W'(1)) begin
                dwe        = 1'b1;
                flush_d    = taps - CNT_W'(2);
                last_run_d = 1'b1;
                wp_d       = waddr;
                k_d        = '0;
                mac_clear  = 1'b1;
                state_d    = ST_SUM;
              end else begin
                clr_valid = 1'b1;
              end
            end
          end
        end
      end
      ST_SUM: begin
        if (k_q < taps) begin
          issue = 1'b1;
          k_d   = k_q + CNT_W'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!st1_v_q && !mac_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_o.valid || out_o.ready) begin
          out_load = 1'b1;
          if (flush_q != '0) begin
            // Next tail sum: shift a zero in and sum again.
            dwe       = 1'b1;
            flush_d   = flush_q - CNT_W'(1);
            wp_d      = waddr;
            k_d       = '0;
            mac_clear = 1'b1;
            state_d   = ST_SUM;
          end else begin
            if (last_run_q) begin
              clr_valid = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      wp_q       <= '0;
      fpos_q     <= '0;
      flush_q    <= '0;
      last_run_q <= 1'b0;
      st1_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      wp_q       <= wp_d;
      fpos_q     <= fpos_d;
      flush_q    <= flush_d;
      last_run_q <= last_run_d;
      st1_v_q    <= issue;
    end
  end

  // Kernel memory: written by coefficient loads, read one tap per cycle.
  logic signed [SAMPLE_BITS-1:0] kmem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] kdat_q;

  always_ff @(posedge clk_i) begin
    if (kwe) begin
      kmem[TAP_W'(in_i.coeff_index)] <= in_i.value;
    end
    kdat_q <= kmem[k_q[TAP_W-1:0]];
  end

  // Delay line memory as a circular buffer. A per-entry valid bit makes an
  // entry read as zero until it is written after reset or after a flush.
  logic signed [SAMPLE_BITS-1:0] dmem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] ddat_q;
  logic [MAX_TAPS-1:0]           dvalid_q;
  logic                          dval_q;

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dmem[waddr] <= dwdata;
    end
    ddat_q <= dmem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
      dval_q   <= 1'b0;
    end else begin
      if (clr_valid) begin
        dvalid_q <= '0;
      end else if (dwe) begin
        dvalid_q[waddr] <= 1'b1;
      end
      dval_q <= dvalid_q[raddr];
    end
  end

  // Shared multiply-accumulate.
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic signed [SUM_W-1:0]       mac_acc;

  assign mac_ctrl.clear = mac_clear;
  assign mac_ctrl.valid = st1_v_q;
  assign mac_sample     = dval_q ? ddat_q : '0;

  firlc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (mac_sample),
    .coeff_i  (kdat_q),
    .acc_o    (mac_acc),
    .busy_o   (mac_busy)
  );

  // Output register; it frees the sequencer to accept the next input
  // transaction while a finished sum waits to be taken.
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_q <= mac_acc;
      eor_q <= last_run_q && (flush_q == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sum        = sum_q;
  assign out_o.end_of_run = eor_q;

endmodule

### tb/tb_fir_linear_convolution_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for fir_linear_convolution_unit: a scoreboard class predicts every
// convolution sum from the accepted input transactions and checks the result stream against it.
// Depends on firlc_pkg and the channel interfaces firlc_in_if and firlc_out_if.

import firlc_pkg::*;

typedef struct {
  logic signed [SUM_W-1:0] sum;
  logic                    end_of_run;
} conv_result_t;

// Keeps a private copy of the kernel, the delay line, the frame position and both
// registers, and queues the sums that each accepted transaction must produce.
class conv_scoreboard;
  logic signed [SAMPLE_BITS-1:0] kernel [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
  logic [FPOS_W-1:0]             frame_pos;
  logic [TAPCFG_W-1:0]           tap_reg;
  logic [STRIDE_W-1:0]           stride_reg;
  conv_result_t                  sums_due [$];
  int unsigned                   errors;

  function new();
    tap_reg    = TAPCFG_W'(MAX_TAPS);
    stride_reg = STRIDE_W'(1);
    frame_pos  = '0;
    errors     = 0;
    foreach (kernel[k]) begin
      kernel[k]  = '0;
      history[k] = '0;
    end
  endfunction

  function int unsigned live_taps();
    if (tap_reg == 0) return 1;
    if (tap_reg > MAX_TAPS) return MAX_TAPS;
    return tap_reg;
  endfunction

  function int unsigned live_stride();
    if (stride_reg == 0) return 1;
    if (stride_reg > MAX_STRIDE) return MAX_STRIDE;
    return stride_reg;
  endfunction

  function int unsigned pending();
    return sums_due.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_TAP_COUNT) tap_reg = data[TAPCFG_W-1:0];
    else if (idx == REG_CHANNEL_STRIDE) stride_reg = data[STRIDE_W-1:0];
  endfunction

  // Shifts one sample into the delay line and forms the sum over the taps in use.
  function logic signed [SUM_W-1:0] shift_in(logic signed [SAMPLE_BITS-1:0] sample,
                                             int unsigned taps);
    logic signed [SUM_W-1:0] acc;
    acc = '0;
    for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = sample;
    for (int k = 0; k < taps; k++) acc += history[k] * kernel[k];
    return acc;
  endfunction

  function void push_sum(logic signed [SUM_W-1:0] sum);
    conv_result_t r;
    r.sum        = sum;
    r.end_of_run = 1'b0;
    sums_due.insert(sums_due.size(), r);
  endfunction

  function void note_input(action_e act, logic [COEFF_IDX_W-1:0] idx,
                           logic signed [SAMPLE_BITS-1:0] value, logic last);
    int unsigned taps;
    int unsigned given;
    taps  = live_taps();
    given = 0;
    if (act == ACT_LOAD) begin
      kernel[idx] = value;
      return;
    end
    if (frame_pos == 0) begin
      push_sum(shift_in(value, taps));
      given++;
    end
    frame_pos = (frame_pos + 1 >= live_stride()) ? '0 : frame_pos + 1'b1;
    if (last) begin
      for (int i = 1; i < taps; i++) begin
        push_sum(shift_in('0, taps));
        given++;
      end
      if (given > 0) sums_due[sums_due.size()-1].end_of_run = 1'b1;
      foreach (history[k]) history[k] = '0;
      frame_pos = '0;
    end
  endfunction

  task report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(logic signed [SUM_W-1:0] sum, logic end_of_run);
    conv_result_t want;
    if (sums_due.size() == 0) begin
      report($sformatf("unexpected result sum=%0d end_of_run=%0b", sum, end_of_run));
      return;
    end
    want = sums_due.pop_front();
    if (sum !== want.sum)
      report($sformatf("sum got %0d, want %0d", sum, want.sum));
    if (end_of_run !== want.end_of_run)
      report($sformatf("end_of_run got %0b, want %0b (sum %0d)",
                       end_of_run, want.end_of_run, want.sum));
  endtask
endclass

module tb_fir_linear_convolution_unit;
  import firlc_pkg::*;

  // Number of random input transactions after the directed part.
  localparam int RANDOM_ITEMS = 160;
  // The settle wait is sized to outlast any work that is still in flight after the last expected
  // result, such as a trailing coefficient load.
  localparam int SETTLE_CYCLES = 2 * (MAX_TAPS + 4) + 16;
  // The slowest correct run would have every one of roughly 300 transactions flush a full
  // 64-tap tail, stalls included. The limit sits several times above that, so it only ever
  // ends a hung run.
  localparam int LIMIT_CYCLES = 10_000_000;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  firlc_in_if  in_ch ();
  firlc_out_if out_ch ();

  conv_scoreboard board;
  int unsigned    idle_pct;
  int unsigned    items_sent;
  int unsigned    cycle_count = 0;

  fir_linear_convolution_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a run that never drains its expected sums ends here.
  initial begin
    wait (cycle_count == LIMIT_CYCLES);
    $display("tb_fir_linear_convolution_unit failed");
    $finish;
  end

  // The result side stalls at random, changing ready only at the falling edge. While
  // idle_pct is zero the receiver never stalls.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Every result transaction is checked at the rising edge where it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_result(out_ch.sum, out_ch.end_of_run);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
    case ($urandom_range(9))
      0: return SMP_MIN;
      1: return SMP_MAX;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offers one input transaction, entered and left at a falling edge. Valid stays high
  // on return so that a following transaction can go out back to back; a random idle
  // cycle and a drain are the only places it drops.
  task automatic send(action_e act, logic [COEFF_IDX_W-1:0] idx,
                      logic signed [SAMPLE_BITS-1:0] value, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.action      = act;
    in_ch.coeff_index = idx;
    in_ch.value       = value;
    in_ch.last_sample = last;
    in_ch.valid       = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_input(act, idx, value, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // The coefficient index of a sample is don't-care, so it carries random bits.
  task automatic put_sample(logic signed [SAMPLE_BITS-1:0] value, logic last);
    send(ACT_SAMPLE, COEFF_IDX_W'($urandom), value, last);
  endtask

  // A coefficient load ignores its last mark, so that bit is random too.
  task automatic put_coeff(logic [COEFF_IDX_W-1:0] idx, logic signed [SAMPLE_BITS-1:0] value);
    send(ACT_LOAD, idx, value, 1'($urandom_range(1)));
  endtask

  // Holds the input side until every expected sum has arrived. With settle set it also
  // waits out work that produces no result, which makes a register write safe.
  task automatic drain(bit settle);
    in_ch.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // One signal of whole frames with random content. The final frame is cut at a random
  // position, which carries the last mark when the signal is well formed; otherwise the
  // signal simply stops and leaves the delay line and frame position as they are.
  task automatic play_signal(int unsigned frames, bit mark_last);
    int unsigned stride;
    int unsigned cut;
    stride = board.live_stride();
    cut    = $urandom_range(stride - 1);
    for (int f = 0; f < frames; f++) begin
      // Now and then a coefficient changes in the middle of a signal.
      if ($urandom_range(9) == 0) put_coeff(COEFF_IDX_W'($urandom), rand_value());
      for (int p = 0; p < stride; p++) begin
        if (f == frames - 1 && p == cut) begin
          put_sample(rand_value(), mark_last);
          break;
        end
        put_sample(rand_value(), 1'b0);
      end
    end
  endtask

  // A few loose transactions: stray loads and samples with random last marks.
  task automatic play_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(1) == 0) put_coeff(COEFF_IDX_W'($urandom), rand_value());
      else put_sample(rand_value(), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    int unsigned taps;
    int unsigned frames;
    int unsigned pick;

    board             = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_LOAD;
    in_ch.coeff_index = '0;
    in_ch.value       = '0;
    in_ch.last_sample = 1'b0;
    idle_pct          = 6;
    items_sent        = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The kernel store powers up undefined, so every tap is written before the first
    // sample. The first two taps hold the most negative and the most positive values.
    for (int k = 0; k < MAX_TAPS; k++) begin
      if (k == 0) put_coeff(COEFF_IDX_W'(k), SMP_MIN);
      else if (k == 1) put_coeff(COEFF_IDX_W'(k), SMP_MAX);
      else put_coeff(COEFF_IDX_W'(k), rand_value());
    end

    // Reset settings, 64 taps and stride 1. A load with the last mark set must not
    // flush anything. The extreme samples meet the extreme taps, and the last sample
    // flushes the 63 tail sums.
    send(ACT_LOAD, 6'd5, SMP_MAX, 1'b1);
    put_sample(SMP_MIN, 1'b0);
    put_sample(SMP_MAX, 1'b0);
    put_sample(SAMPLE_BITS'(1), 1'b0);
    put_sample('1, 1'b0);
    put_sample('0, 1'b1);
    drain(1'b1);

    // One tap with stride 3: the last mark lands on a skipped position, so nothing at
    // all comes back for it. A filtered last sample then gives a single flagged sum.
    write_cfg(REG_TAP_COUNT, 7'd1);
    write_cfg(REG_CHANNEL_STRIDE, 7'd3);
    put_sample(SMP_MIN, 1'b0);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b1);
    put_sample(SMP_MAX, 1'b1);
    drain(1'b1);

    // A tap count of zero and a stride of zero both behave as one.
    write_cfg(REG_TAP_COUNT, 7'd0);
    write_cfg(REG_CHANNEL_STRIDE, 7'd0);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b1);
    drain(1'b1);

    // All data bits set: the tap count clips to 64 and the stride to 8. A last mark on
    // a skipped position still flushes 63 sums, and a filtered last sample then gives
    // the most sums one transaction can cause.
    write_cfg(REG_TAP_COUNT, 7'h7f);
    write_cfg(REG_CHANNEL_STRIDE, 7'h7f);
    put_sample(SMP_MAX, 1'b0);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b1);
    put_sample(SMP_MIN, 1'b1);
    drain(1'b1);

    // Five taps at stride 2, stopped in the middle of a frame. Dropping the stride to 1
    // makes the stale position wrap on the next sample, and the tap count grows to 8
    // while the delay line still holds the earlier samples.
    write_cfg(REG_TAP_COUNT, 7'd5);
    write_cfg(REG_CHANNEL_STRIDE, 7'd2);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b0);
    drain(1'b1);
    write_cfg(REG_CHANNEL_STRIDE, 7'd1);
    write_cfg(REG_TAP_COUNT, 7'd8);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b0);
    put_sample(rand_value(), 1'b1);

    // Random part: one setting per phase, each phase a handful of signals. Most are
    // well formed with random content; some are stray transactions or signals that stop
    // without a last mark, so later signals start from a dirty delay line. Small kernels
    // dominate to keep the run short, with a full 64-tap phase now and then.
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain(1'b1);
      phase++;
      // The third phase runs with neither side ever stalling.
      idle_pct = (phase == 3) ? 0 : 6;

      pick = $urandom_range(19);
      if (pick < 14) taps = $urandom_range(1, 12);
      else if (pick < 16) taps = MAX_TAPS;
      else if (pick < 18) taps = $urandom_range(13, MAX_TAPS - 1);
      else taps = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_TAPS + 1, 127);
      // Sometimes the tap count is left alone so that a stopped signal carries over.
      if (phase == 1 || $urandom_range(3) != 0) write_cfg(REG_TAP_COUNT, CFG_DATA_W'(taps));

      case ($urandom_range(3))
        0: write_cfg(REG_CHANNEL_STRIDE, CFG_DATA_W'(1));
        1: write_cfg(REG_CHANNEL_STRIDE, CFG_DATA_W'($urandom_range(2, MAX_STRIDE)));
        2: write_cfg(REG_CHANNEL_STRIDE, CFG_DATA_W'($urandom_range(1, 3)));
        default: write_cfg(REG_CHANNEL_STRIDE, CFG_DATA_W'($urandom_range(0, 15)));
      endcase

      repeat ($urandom_range(3, 6)) begin
        frames = (board.live_taps() > 12) ? $urandom_range(1, 3) : $urandom_range(1, 8);
        pick   = $urandom_range(9);
        if (pick == 0) play_noise();
        else if (pick == 1) play_signal(frames, 1'b0);
        else play_signal(frames, 1'b1);
        // Occasionally the sender holds back until the result stream is empty.
        if ($urandom_range(15) == 0) drain(1'b0);
      end
    end

    // Wait for the last sums, then long enough to catch any result that should not come.
    drain(1'b1);
    if (board.errors == 0) begin
      $display("tb_fir_linear_convolution_unit passed");
    end else begin
      $display("tb_fir_linear_convolution_unit failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/firlc_pkg.sv
src/firlc_if.sv
src/firlc_mac.sv
src/fir_linear_convolution_unit.sv
tb/tb_fir_linear_convolution_unit.sv
